// File: src/urfsm_pkg.sv
// shared types, field layout and constants for the upstream registration client
`default_nettype none

package urfsm_pkg;

    // timestamp width, elapsed time is taken modulo 2^TIME_BITS
    localparam int TIME_BITS = 32;
    localparam int LIMIT_W   = 32;
    localparam int CMP_W     = (TIME_BITS > LIMIT_W) ? TIME_BITS : LIMIT_W;

    localparam int ID_W      = 32;
    localparam int STRATUM_W = 8;
    localparam int SIGNAL_W  = 9;
    localparam int STATUS_W  = 8;
    localparam int SLOT_W    = 8;
    localparam int TIMEMS_W  = 32;
    localparam int RETRY_W   = 8;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    typedef logic [TIME_BITS-1:0] stamp_t;

    typedef enum logic [1:0] {
        MODE_SCANNING    = 2'd0,
        MODE_REGISTERING = 2'd1,
        MODE_REGISTERED  = 2'd2,
        MODE_STANDALONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OP_BEACON   = 2'd0,
        OP_RESPONSE = 2'd1,
        OP_TICK     = 2'd2,
        OP_SUB_SENT = 2'd3
    } opcode_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OWN_NODE_ID       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_TIMEOUT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_TIMEOUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEER_LOSS_TIMEOUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_STATUS     = 3'd5;

    // register reset values
    localparam logic [ID_W-1:0]     OWN_NODE_ID_RST       = 32'd0;
    localparam logic [LIMIT_W-1:0]  SCAN_TIMEOUT_RST      = 32'd10000;
    localparam logic [LIMIT_W-1:0]  RESPONSE_TIMEOUT_RST  = 32'd2000;
    localparam logic [LIMIT_W-1:0]  PEER_LOSS_TIMEOUT_RST = 32'd30000;
    localparam logic [RETRY_W-1:0]  RETRY_LIMIT_RST       = 8'd3;
    localparam logic [STATUS_W-1:0] ACCEPT_STATUS_RST     = 8'd0;

    localparam logic [STRATUM_W-1:0] STRATUM_UNKNOWN = 8'hFF;
    localparam logic [STRATUM_W-1:0] STRATUM_MAX     = 8'd254;
    localparam logic [STRATUM_W-1:0] STRATUM_ROOT    = 8'd0;
    localparam logic [SLOT_W-1:0]    SLOT_NONE       = 8'hFF;
    localparam logic [SIGNAL_W-1:0]  SIGNAL_FLOOR    = 9'h100;
    localparam logic [ID_W-1:0]      PEER_NONE       = 32'd0;

    // input word layout
    localparam int IN_USER_W     = 2;
    localparam int IN_DATA_W     = 104;
    localparam int IN_ID_LSB     = 0;
    localparam int IN_STRAT_LSB  = 32;
    localparam int IN_SIG_LSB    = 40;
    localparam int IN_OPEN_LSB   = 49;
    localparam int IN_STATUS_LSB = 50;
    localparam int IN_SLOT_LSB   = 58;
    localparam int IN_TIME_LSB   = 66;

    // result word, send_request in the lowest bit
    typedef struct packed {
        logic                 ready_res;
        logic [SIGNAL_W-1:0]  peer_signal;
        logic [ID_W-1:0]      peer_node;
        logic [SLOT_W-1:0]    current_slot;
        logic [STRATUM_W-1:0] advertised_stratum;
        mode_t                mode;
        logic                 send_request;
    } result_t;

    localparam int RESULT_W   = $bits(result_t);
    localparam int OUT_DATA_W = 64;

endpackage

`default_nettype wire

// File: src/upstream_registration_fsm_core.sv
// upstream registration client: event-driven four-state machine with one result per word
`default_nettype none

// Registers a mesh gateway with an upstream stratum-0 root. Every input word
// is one event (beacon, registration response, tick, subscription sent),
// selected by s_tuser. The event and the current state go through one pass
// of compare-and-update logic; the new state is written back and the result
// word lands in an output register in the same clock, so a word appears on
// the m_ side the cycle after it is taken. One word per clock is accepted;
// the limit is the single state update path (a 32-bit elapsed-time subtract
// and compare, or the signal strength compare, per event). The output
// register decouples the two sides: a new word is taken whenever the output
// register is empty or is being drained in the same cycle. Configuration
// writes take effect on the next clock and are meant to be done while idle.
module upstream_registration_fsm_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [urfsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [urfsm_pkg::CFG_W-1:0]       cfg_data,
    // event stream in
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // fields from bit 0: opcode
    input  wire logic [urfsm_pkg::IN_USER_W-1:0]   s_tuser,
    // fields from bit 0: sender_id, peer_stratum, signal_dbm, window_open,
    // reply_status, granted_slot, time_ms, zero fill
    input  wire logic [urfsm_pkg::IN_DATA_W-1:0]   s_tdata,
    // result stream out
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // fields from bit 0: send_request, mode, advertised_stratum, current_slot,
    // peer_node, peer_signal, ready_res, zero fill
    output logic [urfsm_pkg::OUT_DATA_W-1:0]       m_tdata
);
    import urfsm_pkg::*;

    // configuration
    logic [ID_W-1:0]     own_node_id_reg;
    logic [LIMIT_W-1:0]  scan_timeout_reg;
    logic [LIMIT_W-1:0]  response_timeout_reg;
    logic [LIMIT_W-1:0]  peer_loss_timeout_reg;
    logic [RETRY_W-1:0]  retry_limit_reg;
    logic [STATUS_W-1:0] accept_status_reg;

    // machine state
    mode_t                mode_reg, mode_next;
    stamp_t               scan_began_reg, scan_began_next;
    stamp_t               request_sent_reg, request_sent_next;
    stamp_t               peer_heard_reg, peer_heard_next;
    logic [RETRY_W-1:0]   retries_reg, retries_next;
    logic [ID_W-1:0]      peer_reg, peer_next;
    logic [SIGNAL_W-1:0]  signal_reg, signal_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [STRATUM_W-1:0] stratum_reg, stratum_next;
    logic                 tx_pending_reg, tx_pending_next;
    logic                 send_next;

    // output register
    logic    out_valid_reg;
    result_t result_reg, result_next;

    // event fields
    opcode_t              op;
    logic [ID_W-1:0]      ev_id;
    logic [STRATUM_W-1:0] ev_strat;
    logic [SIGNAL_W-1:0]  ev_sig;
    logic                 ev_open;
    logic [STATUS_W-1:0]  ev_status;
    logic [SLOT_W-1:0]    ev_slot;
    stamp_t               now;
    logic                 accept;
    logic                 take_beacon;

    function automatic logic elapsed(stamp_t now_t, stamp_t then_t,
                                     logic [LIMIT_W-1:0] limit);
        stamp_t diff;
        diff = now_t - then_t;
        return CMP_W'(diff) >= CMP_W'(limit);
    endfunction

    assign op        = opcode_t'(s_tuser);
    assign ev_id     = s_tdata[IN_ID_LSB +: ID_W];
    assign ev_strat  = s_tdata[IN_STRAT_LSB +: STRATUM_W];
    assign ev_sig    = s_tdata[IN_SIG_LSB +: SIGNAL_W];
    assign ev_open   = s_tdata[IN_OPEN_LSB];
    assign ev_status = s_tdata[IN_STATUS_LSB +: STATUS_W];
    assign ev_slot   = s_tdata[IN_SLOT_LSB +: SLOT_W];
    assign now       = TIME_BITS'(s_tdata[IN_TIME_LSB +: TIMEMS_W]);

    // take a word when the result slot is free or drains this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // while scanning, an empty slot or a strictly stronger signal wins
    assign take_beacon = (peer_reg == PEER_NONE) ||
                         ($signed(ev_sig) > $signed(signal_reg));

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_node_id_reg       <= OWN_NODE_ID_RST;
            scan_timeout_reg      <= SCAN_TIMEOUT_RST;
            response_timeout_reg  <= RESPONSE_TIMEOUT_RST;
            peer_loss_timeout_reg <= PEER_LOSS_TIMEOUT_RST;
            retry_limit_reg       <= RETRY_LIMIT_RST;
            accept_status_reg     <= ACCEPT_STATUS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OWN_NODE_ID:       own_node_id_reg       <= cfg_data[ID_W-1:0];
                REG_SCAN_TIMEOUT:      scan_timeout_reg      <= cfg_data[LIMIT_W-1:0];
                REG_RESPONSE_TIMEOUT:  response_timeout_reg  <= cfg_data[LIMIT_W-1:0];
                REG_PEER_LOSS_TIMEOUT: peer_loss_timeout_reg <= cfg_data[LIMIT_W-1:0];
                REG_RETRY_LIMIT:       retry_limit_reg       <= cfg_data[RETRY_W-1:0];
                REG_ACCEPT_STATUS:     accept_status_reg     <= cfg_data[STATUS_W-1:0];
                default:               ;
            endcase
        end
    end

    // next state for one event
    always_comb
    begin
        mode_next         = mode_reg;
        scan_began_next   = scan_began_reg;
        request_sent_next = request_sent_reg;
        peer_heard_next   = peer_heard_reg;
        retries_next      = retries_reg;
        peer_next         = peer_reg;
        signal_next       = signal_reg;
        slot_next         = slot_reg;
        stratum_next      = stratum_reg;
        tx_pending_next   = tx_pending_reg;
        send_next         = 1'b0;

        case (op)
            OP_BEACON:
            begin
                // only stratum-0 roots count
                if (ev_strat == STRATUM_ROOT)
                begin
                    case (mode_reg)
                        MODE_SCANNING:
                        begin
                            if (take_beacon)
                            begin
                                peer_next   = ev_id;
                                signal_next = ev_sig;
                            end
                            peer_heard_next = now;
                            if (ev_open && (take_beacon || peer_reg == ev_id))
                                tx_pending_next = 1'b1;
                        end
                        MODE_REGISTERING:
                        begin
                            if (ev_id == peer_reg)
                            begin
                                signal_next     = ev_sig;
                                peer_heard_next = now;
                                if (ev_open)
                                    tx_pending_next = 1'b1;
                            end
                        end
                        MODE_REGISTERED:
                        begin
                            if (ev_id == peer_reg)
                            begin
                                signal_next     = ev_sig;
                                peer_heard_next = now;
                            end
                        end
                        default:
                        begin
                            // standalone yields to a lower-id root with an open window
                            if (ev_id < own_node_id_reg && ev_open)
                            begin
                                mode_next       = MODE_SCANNING;
                                scan_began_next = now;
                                retries_next    = '0;
                                stratum_next    = STRATUM_UNKNOWN;
                                peer_next       = ev_id;
                                signal_next     = ev_sig;
                                peer_heard_next = now;
                                tx_pending_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            OP_RESPONSE:
            begin
                if (mode_reg == MODE_REGISTERING)
                begin
                    if (ev_status == accept_status_reg)
                    begin
                        mode_next       = MODE_REGISTERED;
                        slot_next       = ev_slot;
                        stratum_next    = (ev_strat < STRATUM_MAX) ?
                                          ev_strat + 8'd1 : STRATUM_MAX;
                        peer_heard_next = now;
                    end
                    else
                    begin
                        mode_next       = MODE_SCANNING;
                        scan_began_next = now;
                        peer_next       = PEER_NONE;
                        retries_next    = '0;
                        tx_pending_next = 1'b0;
                        stratum_next    = STRATUM_UNKNOWN;
                    end
                end
            end
            OP_TICK:
            begin
                case (mode_reg)
                    MODE_SCANNING:
                    begin
                        if (tx_pending_reg)
                            send_next = 1'b1;
                        else if (elapsed(now, scan_began_reg, scan_timeout_reg))
                        begin
                            mode_next    = MODE_STANDALONE;
                            stratum_next = STRATUM_ROOT;
                        end
                    end
                    MODE_REGISTERING:
                    begin
                        if (tx_pending_reg)
                            send_next = 1'b1;
                        else if (elapsed(now, request_sent_reg, response_timeout_reg))
                        begin
                            if (retries_reg < retry_limit_reg)
                            begin
                                retries_next    = retries_reg + 8'd1;
                                tx_pending_next = 1'b1;
                                send_next       = 1'b1;
                            end
                            else
                            begin
                                mode_next       = MODE_SCANNING;
                                scan_began_next = now;
                                peer_next       = PEER_NONE;
                                retries_next    = '0;
                                tx_pending_next = 1'b0;
                                stratum_next    = STRATUM_UNKNOWN;
                            end
                        end
                    end
                    MODE_REGISTERED:
                    begin
                        // upstream gone quiet
                        if (elapsed(now, peer_heard_reg, peer_loss_timeout_reg))
                        begin
                            mode_next       = MODE_SCANNING;
                            scan_began_next = now;
                            peer_next       = PEER_NONE;
                            retries_next    = '0;
                            tx_pending_next = 1'b0;
                            stratum_next    = STRATUM_UNKNOWN;
                        end
                    end
                    default: ;
                endcase
            end
            default:
            begin
                // subscription sent
                request_sent_next = now;
                tx_pending_next   = 1'b0;
                if (mode_reg == MODE_SCANNING)
                    mode_next = MODE_REGISTERING;
            end
        endcase
    end

    // result word from the updated state
    always_comb
    begin
        result_next.send_request       = send_next;
        result_next.mode               = mode_next;
        result_next.advertised_stratum = stratum_next;
        result_next.current_slot       = (mode_next == MODE_REGISTERED) ? slot_next : SLOT_NONE;
        result_next.peer_node          = peer_next;
        result_next.peer_signal        = signal_next;
        result_next.ready_res          = (mode_next == MODE_REGISTERED) ||
                                         (mode_next == MODE_STANDALONE);
    end

    // state update on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_SCANNING;
            scan_began_reg   <= '0;
            request_sent_reg <= '0;
            peer_heard_reg   <= '0;
            retries_reg      <= '0;
            peer_reg         <= PEER_NONE;
            signal_reg       <= SIGNAL_FLOOR;
            slot_reg         <= SLOT_NONE;
            stratum_reg      <= STRATUM_UNKNOWN;
            tx_pending_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg         <= mode_next;
            scan_began_reg   <= scan_began_next;
            request_sent_reg <= request_sent_next;
            peer_heard_reg   <= peer_heard_next;
            retries_reg      <= retries_next;
            peer_reg         <= peer_next;
            signal_reg       <= signal_next;
            slot_reg         <= slot_next;
            stratum_reg      <= stratum_next;
            tx_pending_reg   <= tx_pending_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(result_reg);

endmodule

`default_nettype wire

// File: src/urfsm_checker.sv
// port-level checks for the upstream registration client, bound to the top level
`default_nettype none

module urfsm_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [urfsm_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import urfsm_pkg::*;

    result_t res;
    assign res = result_t'(m_tdata[RESULT_W-1:0]);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // every accepted word yields a result on the next cycle
    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted word produced no result");

    // ready flag follows the reported mode
    a_ready_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> res.ready_res ==
            ((res.mode == MODE_REGISTERED) || (res.mode == MODE_STANDALONE)))
        else $error("ready flag disagrees with mode");

    // a slot is only shown while registered
    a_slot_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.mode != MODE_REGISTERED |-> res.current_slot == SLOT_NONE)
        else $error("slot shown outside registered");

    // send requests only come out of scanning or registering
    a_send_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.send_request |->
            (res.mode == MODE_SCANNING) || (res.mode == MODE_REGISTERING))
        else $error("send request in a settled mode");

endmodule

bind upstream_registration_fsm_core urfsm_checker u_urfsm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
